@@ src/bup_pkg.sv @@
// bup_pkg: shared types, codes and field-map helpers for the bmp pixel unpacker
`timescale 1ns / 1ps

package bup_pkg;

   localparam int PALETTE_DEPTH = 256;
   localparam int PAL_IDX_W     = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 32;
   localparam int NUM_CH        = 4;

   // channel slots in the field-map arrays
   localparam int CH_RED   = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 2;
   localparam int CH_ALPHA = 3;

   localparam logic OP_CONVERT   = 1'b0;
   localparam logic OP_PAL_WRITE = 1'b1;

   localparam logic [7:0] OPAQUE = 8'hFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PIXEL_FORMAT = 3'd0,
      CSR_FORCE_OPAQUE = 3'd1,
      CSR_RED_MASK     = 3'd2,
      CSR_GREEN_MASK   = 3'd3,
      CSR_BLUE_MASK    = 3'd4,
      CSR_ALPHA_MASK   = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      FMT_PALETTE   = 2'd0,
      FMT_RGB24     = 2'd1,
      FMT_RGB32     = 2'd2,
      FMT_BITFIELDS = 2'd3
   } format_type;

   typedef logic [4:0] bit_pos_type;

   // per output bit: which word bit feeds it, and whether the mask keeps it
   typedef struct packed {
      logic                   nonzero;
      logic [7:0]             live;
      bit_pos_type [7:0]      sel;
   } field_map_type;

   typedef struct packed {
      format_type                  pixel_format;
      logic                        force_opaque;
      field_map_type [NUM_CH-1:0]  map;
   } conv_cfg_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } rgba_type;

   localparam logic [NUM_CH-1:0][31:0] MASK_RESET =
      {32'hFF000000, 32'h000000FF, 32'h0000FF00, 32'h00FF0000};
   localparam bit_pos_type [NUM_CH-1:0] TZ_RESET =
      {5'd24, 5'd0, 5'd8, 5'd16};

   // a mod w for a below 8 and w from 1 to 7
   function automatic logic [2:0] mod_small(input logic [2:0] a, input logic [2:0] w);
      logic [2:0] r;
      r = a;
      for (int i = 0; i < 7; i++) begin
         if (r >= w) begin
            r = r - w;
         end
      end
      return r;
   endfunction

   function automatic field_map_type build_map(input logic [31:0] mask,
                                               input bit_pos_type tz,
                                               input bit_pos_type msb,
                                               input logic found);
      field_map_type m;
      logic [5:0]    width;
      logic [2:0]    w3;
      logic [2:0]    p;
      bit_pos_type   pos;
      width     = 6'(msb) - 6'(tz) + 6'd1;
      w3        = width[2:0];
      m.nonzero = found;
      for (int k = 0; k < 8; k++) begin
         if (width >= 6'd8) begin
            pos = tz + 5'(k);
         end else begin
            // narrow field sits at the top of the byte and repeats downward
            p   = mod_small(3'(7 - k), w3);
            pos = tz + 5'(w3) - 5'd1 - 5'(p);
         end
         m.sel[k]  = pos;
         m.live[k] = found & mask[pos];
      end
      return m;
   endfunction

   function automatic logic [7:0] extract_field(input logic [31:0] word,
                                                input field_map_type m);
      logic [7:0] v;
      for (int k = 0; k < 8; k++) begin
         v[k] = m.live[k] & word[m.sel[k]];
      end
      return v;
   endfunction

endpackage

@@ src/bup_req_if.sv @@
// bup_req_if: input channel carrying convert and palette-write items
`timescale 1ns / 1ps

interface bup_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [31:0] pixel_word;
   logic [7:0]  palette_index;

   modport source (output valid, output operation, output pixel_word,
                   output palette_index, input ready);
   modport sink   (input valid, input operation, input pixel_word,
                   input palette_index, output ready);
endinterface

@@ src/bup_rsp_if.sv @@
// bup_rsp_if: result channel carrying rgba items
`timescale 1ns / 1ps

interface bup_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] alpha;

   modport source (output valid, output red, output green, output blue,
                   output alpha, input ready);
   modport sink   (input valid, input red, input green, input blue,
                   input alpha, output ready);
endinterface

@@ src/bup_field_scan.sv @@
// bup_field_scan: configuration registers and the mask scanner building field maps
`timescale 1ns / 1ps

module bup_field_scan (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [bup_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bup_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output bup_pkg::conv_cfg_type           cfg,
   output logic                            busy
);
   import bup_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } scan_state_type;

   scan_state_type                  state_ff;
   bit_pos_type                     cnt_ff;
   format_type                      format_ff;
   logic                            force_opaque_ff;
   logic [NUM_CH-1:0][31:0]         mask_ff;
   logic [NUM_CH-1:0]               found_ff;
   bit_pos_type [NUM_CH-1:0]        tz_ff;
   bit_pos_type [NUM_CH-1:0]        msb_ff;
   field_map_type [NUM_CH-1:0]      map_ff;

   logic                            mask_wr;
   logic [1:0]                      mask_sel;

   assign mask_wr  = csr_we && (csr_index == CSR_RED_MASK || csr_index == CSR_GREEN_MASK ||
                                csr_index == CSR_BLUE_MASK || csr_index == CSR_ALPHA_MASK);
   assign mask_sel = 2'(csr_index - CSR_RED_MASK);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         cnt_ff          <= '0;
         format_ff       <= FMT_RGB24;
         force_opaque_ff <= 1'b0;
         found_ff        <= '0;
         tz_ff           <= '0;
         msb_ff          <= '0;
         for (int ch = 0; ch < NUM_CH; ch++) begin
            mask_ff[ch] <= MASK_RESET[ch];
            map_ff[ch]  <= build_map(MASK_RESET[ch], TZ_RESET[ch],
                                     TZ_RESET[ch] + 5'd7, 1'b1);
         end
      end else begin
         if (mask_wr) begin
            // any mask change restarts the scan from bit 0
            state_ff <= ST_SCAN;
            cnt_ff   <= '0;
            found_ff <= '0;
         end else begin
            unique case (state_ff)
               ST_IDLE: begin
               end
               ST_SCAN: begin
                  // one mask bit per cycle, all four channels side by side
                  for (int ch = 0; ch < NUM_CH; ch++) begin
                     if (mask_ff[ch][cnt_ff]) begin
                        if (!found_ff[ch]) begin
                           tz_ff[ch]    <= cnt_ff;
                           found_ff[ch] <= 1'b1;
                        end
                        msb_ff[ch] <= cnt_ff;
                     end
                  end
                  cnt_ff <= cnt_ff + 5'd1;
                  if (cnt_ff == 5'd31) begin
                     state_ff <= ST_FINISH;
                  end
               end
               ST_FINISH: begin
                  for (int ch = 0; ch < NUM_CH; ch++) begin
                     map_ff[ch] <= build_map(mask_ff[ch], tz_ff[ch], msb_ff[ch], found_ff[ch]);
                  end
                  state_ff <= ST_IDLE;
               end
               default: begin
                  state_ff <= ST_IDLE;
               end
            endcase
         end

         if (csr_we) begin
            unique case (csr_index)
               CSR_PIXEL_FORMAT: format_ff       <= format_type'(csr_wdata[1:0]);
               CSR_FORCE_OPAQUE: force_opaque_ff <= csr_wdata[0];
               CSR_RED_MASK, CSR_GREEN_MASK, CSR_BLUE_MASK, CSR_ALPHA_MASK: begin
                  mask_ff[mask_sel] <= csr_wdata;
               end
               default: begin
               end
            endcase
         end
      end
   end

   assign busy             = (state_ff != ST_IDLE);
   assign cfg.pixel_format = format_ff;
   assign cfg.force_opaque = force_opaque_ff;
   assign cfg.map          = map_ff;

endmodule

@@ src/bup_convert_pipe.sv @@
// bup_convert_pipe: palette memory, conversion stage and output register
`timescale 1ns / 1ps

module bup_convert_pipe (
   input  logic                   clock,
   input  logic                   reset,
   input  bup_pkg::conv_cfg_type  cfg,
   input  logic                   busy,
   bup_req_if.sink                req,
   bup_rsp_if.source              rsp
);
   import bup_pkg::*;

   logic [23:0]              pal_mem [PALETTE_DEPTH];
   logic [PALETTE_DEPTH-1:0] pal_valid_ff;
   logic [23:0]              rdata_ff;

   logic     s1_valid_ff;
   logic     s1_is_pal_ff;
   logic     s1_hit_ff;
   rgba_type s1_rgba_ff;
   logic     out_valid_ff;
   rgba_type out_rgba_ff;

   logic                 req_fire;
   logic                 out_move;
   logic                 s1_load;
   logic                 is_write;
   logic [7:0]           b0, b1, b2, b3;
   logic                 wr_in_range;
   logic                 rd_in_range;
   logic [PAL_IDX_W-1:0] wr_addr;
   logic [PAL_IDX_W-1:0] rd_addr;
   logic                 wr_en;
   logic                 rd_en;
   logic                 s1_is_pal_in;
   rgba_type             s1_rgba_in;
   rgba_type             out_rgba_in;

   assign out_move  = !out_valid_ff || rsp.ready;
   assign s1_load   = !s1_valid_ff || out_move;
   assign req.ready = !busy && s1_load;
   assign req_fire  = req.valid && req.ready;
   assign is_write  = (req.operation == OP_PAL_WRITE);

   assign {b3, b2, b1, b0} = req.pixel_word;

   assign wr_in_range = (9'(req.palette_index) < 9'(PALETTE_DEPTH));
   assign rd_in_range = (9'(b0) < 9'(PALETTE_DEPTH));
   assign wr_addr     = req.palette_index[PAL_IDX_W-1:0];
   assign rd_addr     = b0[PAL_IDX_W-1:0];
   assign wr_en       = req_fire && is_write && wr_in_range;
   assign rd_en       = req_fire && !is_write;

   // one item per cycle while req.ready is high, so a write and a read never share a
   // cycle and a read always sees every earlier write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         pal_mem[wr_addr] <= {b2, b1, b0};
      end
      if (rd_en) begin
         rdata_ff <= pal_mem[rd_addr];
      end
   end

   always_comb begin
      s1_is_pal_in = 1'b0;
      s1_rgba_in   = '0;
      unique case (cfg.pixel_format)
         FMT_PALETTE: begin
            s1_is_pal_in = 1'b1;
         end
         FMT_RGB24: begin
            s1_rgba_in = '{red: b2, green: b1, blue: b0, alpha: OPAQUE};
         end
         FMT_RGB32: begin
            s1_rgba_in = '{red: b2, green: b1, blue: b0,
                           alpha: cfg.force_opaque ? OPAQUE : b3};
         end
         FMT_BITFIELDS: begin
            s1_rgba_in.red   = extract_field(req.pixel_word, cfg.map[CH_RED]);
            s1_rgba_in.green = extract_field(req.pixel_word, cfg.map[CH_GREEN]);
            s1_rgba_in.blue  = extract_field(req.pixel_word, cfg.map[CH_BLUE]);
            s1_rgba_in.alpha = cfg.map[CH_ALPHA].nonzero ?
                               extract_field(req.pixel_word, cfg.map[CH_ALPHA]) : OPAQUE;
         end
      endcase
   end

   always_comb begin
      if (s1_is_pal_ff) begin
         // entries never written read as zero
         out_rgba_in.red   = s1_hit_ff ? rdata_ff[23:16] : 8'd0;
         out_rgba_in.green = s1_hit_ff ? rdata_ff[15:8]  : 8'd0;
         out_rgba_in.blue  = s1_hit_ff ? rdata_ff[7:0]   : 8'd0;
         out_rgba_in.alpha = OPAQUE;
      end else begin
         out_rgba_in = s1_rgba_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pal_valid_ff <= '0;
      end else begin
         if (s1_load) begin
            s1_valid_ff <= req_fire && !is_write;
         end
         if (out_move) begin
            out_valid_ff <= s1_valid_ff;
         end
         if (wr_en) begin
            pal_valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_is_pal_ff <= s1_is_pal_in;
         s1_hit_ff    <= rd_in_range && pal_valid_ff[rd_addr];
         s1_rgba_ff   <= s1_rgba_in;
      end
      if (s1_valid_ff && out_move) begin
         out_rgba_ff <= out_rgba_in;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.red   = out_rgba_ff.red;
   assign rsp.green = out_rgba_ff.green;
   assign rsp.blue  = out_rgba_ff.blue;
   assign rsp.alpha = out_rgba_ff.alpha;

endmodule

@@ src/bmp_pixel_unpacker.sv @@
// bmp_pixel_unpacker: top level, bmp source pixel words in, rgba items out
//
//   port   dir  handshake          carries
//   req    in   valid / ready      operation, pixel_word, palette_index
//   rsp    out  valid / ready      red, green, blue, alpha
//   csr    in   csr_we             csr_index, csr_wdata (write only)
//
// one item per clock while req.ready is high; a result passes the first stage
// and output registers, and palette writes give no result
// palette reads go through a synchronous memory read port
// a write to any mask register starts a mask scan, req.ready low
// reset is synchronous: control state and the palette valid bits clear at once
// an rsp stall backs up through the output and first stage registers
`timescale 1ns / 1ps

module bmp_pixel_unpacker (
   input  logic                            clock,
   input  logic                            reset,
   bup_req_if.sink                         req,
   bup_rsp_if.source                       rsp,
   input  logic                            csr_we,
   input  logic [bup_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bup_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import bup_pkg::*;

   conv_cfg_type cfg;
   logic         busy;

   bup_field_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .busy      (busy)
   );

   bup_convert_pipe u_pipe (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .busy  (busy),
      .req   (req),
      .rsp   (rsp)
   );

endmodule

@@ src/bup_checker.sv @@
// bup_checker: port-level assertions for the bmp pixel unpacker, with its bind
`timescale 1ns / 1ps

module bup_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [31:0]                    rsp_data,
   input logic                           csr_we,
   input logic [bup_pkg::CSR_IDX_W-1:0]  csr_index
);
   import bup_pkg::*;

   // a held result stays offered until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("result item changed while stalled");

   // the mask scan blocks new items straight after a mask write
   a_scan_blocks: assert property (@(posedge clock) disable iff (reset)
      csr_we && (csr_index == CSR_RED_MASK || csr_index == CSR_GREEN_MASK ||
                 csr_index == CSR_BLUE_MASK || csr_index == CSR_ALPHA_MASK)
      |=> !req_ready)
      else $error("item taken during mask scan");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered straight after reset");

endmodule

bind bmp_pixel_unpacker bup_checker u_bup_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_data  ({rsp.red, rsp.green, rsp.blue, rsp.alpha}),
   .csr_we    (csr_we),
   .csr_index (csr_index)
);

@@ tb/bmp_pixel_unpacker_tb.sv @@
// bmp_pixel_unpacker_tb: self-checking testbench, directed and random pixel streams
`timescale 1ns / 1ps

module bmp_pixel_unpacker_tb;
   import bup_pkg::*;

   localparam int HALF_PERIOD = 6;
   localparam int ITEMS_PER_PHASE = 78;
   // run limit in clock cycles, meant to cover long stalls and mask scans
   localparam int RUN_LIMIT_CYCLES = 300_000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   bup_req_if req_if ();
   bup_rsp_if rsp_if ();

   bmp_pixel_unpacker i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow of the block's registers and palette
   format_type    cur_format;
   logic          cur_opaque;
   logic [31:0]   cur_mask [NUM_CH];
   logic [23:0]   palette_rgb [PALETTE_DEPTH];

   rgba_type      rgba_due [$];
   rgba_type      rgba_want;
   int            errors = 0;
   int            send_idle_pct = 0;
   int            recv_stall_pct = 0;

   always #HALF_PERIOD clock = ~clock;

   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (rgba_due.size() == 0) begin
            $error("unexpected item: red %0h green %0h blue %0h alpha %0h",
                   rsp_if.red, rsp_if.green, rsp_if.blue, rsp_if.alpha);
            errors++;
         end else begin
            rgba_want = rgba_due.pop_front();
            if (rsp_if.red !== rgba_want.red) begin
               $error("red: expected %0h, got %0h", rgba_want.red, rsp_if.red);
               errors++;
            end
            if (rsp_if.green !== rgba_want.green) begin
               $error("green: expected %0h, got %0h", rgba_want.green, rsp_if.green);
               errors++;
            end
            if (rsp_if.blue !== rgba_want.blue) begin
               $error("blue: expected %0h, got %0h", rgba_want.blue, rsp_if.blue);
               errors++;
            end
            if (rsp_if.alpha !== rgba_want.alpha) begin
               $error("alpha: expected %0h, got %0h", rgba_want.alpha, rsp_if.alpha);
               errors++;
            end
         end
      end
   end

   // one channel through a bitfields mask, narrow fields replicated downward
   function automatic logic [7:0] mask_field(input logic [31:0] word, input logic [31:0] mask);
      logic [31:0] v;
      logic [31:0] m;
      int          width;
      logic [7:0]  r;
      if (mask == '0) begin
         return 8'h00;
      end
      v = word & mask;
      m = mask;
      while (m[0] == 1'b0) begin
         v = v >> 1;
         m = m >> 1;
      end
      width = 0;
      while (m != '0) begin
         width++;
         m = m >> 1;
      end
      if (width >= 8) begin
         return v[7:0];
      end
      r = 8'(v << (8 - width));
      for (int s = width; s < 8; s += width) begin
         r = r | (r >> width);
      end
      return r;
   endfunction

   // returns 1 when the item gives a result
   function automatic bit unpack_pixel(input logic op, input logic [31:0] word,
                                       input logic [7:0] idx, output rgba_type px);
      logic [23:0] entry;
      px    = '0;
      entry = '0;
      if (op == OP_PAL_WRITE) begin
         if (int'(idx) < PALETTE_DEPTH) begin
            palette_rgb[idx] = word[23:0];
         end
         return 1'b0;
      end
      case (cur_format)
         FMT_PALETTE: begin
            if (int'(word[7:0]) < PALETTE_DEPTH) begin
               entry = palette_rgb[word[7:0]];
            end
            px = '{entry[23:16], entry[15:8], entry[7:0], OPAQUE};
         end
         FMT_RGB24: begin
            px = '{word[23:16], word[15:8], word[7:0], OPAQUE};
         end
         FMT_RGB32: begin
            px = '{word[23:16], word[15:8], word[7:0], cur_opaque ? OPAQUE : word[31:24]};
         end
         default: begin
            px.red   = mask_field(word, cur_mask[CH_RED]);
            px.green = mask_field(word, cur_mask[CH_GREEN]);
            px.blue  = mask_field(word, cur_mask[CH_BLUE]);
            px.alpha = (cur_mask[CH_ALPHA] == '0) ? OPAQUE
                       : mask_field(word, cur_mask[CH_ALPHA]);
         end
      endcase
      return 1'b1;
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_item(input logic op, input logic [31:0] word, input logic [7:0] idx);
      rgba_type px;
      while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.operation     <= op;
      req_if.pixel_word    <= word;
      req_if.palette_index <= idx;
      do begin
         @(posedge clock);
      end while (!req_if.ready);
      if (unpack_pixel(op, word, idx, px)) begin
         rgba_due.insert(rgba_due.size(), px);
      end
      @(negedge clock);
   endtask

   // wait until every result is in, then let palette writes settle
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (rgba_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (6) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [31:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_PIXEL_FORMAT: cur_format = format_type'(data[1:0]);
         CSR_FORCE_OPAQUE: cur_opaque = data[0];
         CSR_RED_MASK:     cur_mask[CH_RED] = data;
         CSR_GREEN_MASK:   cur_mask[CH_GREEN] = data;
         CSR_BLUE_MASK:    cur_mask[CH_BLUE] = data;
         CSR_ALPHA_MASK:   cur_mask[CH_ALPHA] = data;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      // a mask write holds off the input channel while the mask is scanned
      if (idx != CSR_PIXEL_FORMAT && idx != CSR_FORCE_OPAQUE) begin
         while (!req_if.ready) begin
            @(negedge clock);
         end
      end
   endtask

   task automatic write_masks(input logic [31:0] r, input logic [31:0] g,
                              input logic [31:0] b, input logic [31:0] a);
      write_reg(CSR_RED_MASK, r);
      write_reg(CSR_GREEN_MASK, g);
      write_reg(CSR_BLUE_MASK, b);
      write_reg(CSR_ALPHA_MASK, a);
   endtask

   function automatic logic [31:0] rand_mask();
      int w;
      int pos;
      case ($urandom_range(0, 7))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2: return 32'h1 << $urandom_range(0, 31);
         3: return $urandom();
         default: begin
            w   = $urandom_range(1, 12);
            pos = $urandom_range(0, 32 - w);
            return 32'(((64'h1 << w) - 1) << pos);
         end
      endcase
   endfunction

   task automatic set_idling(input int mode);
      case (mode)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
         default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
   endtask

   // reset settings: 24-bit swap, top byte ignored
   task automatic test_rgb24();
      send_item(OP_CONVERT, 32'h0000_0000, 8'h00);
      send_item(OP_CONVERT, 32'hFFFF_FFFF, 8'hFF);
      send_item(OP_CONVERT, 32'hA5C3_E10F, 8'h5A);
      send_item(OP_CONVERT, 32'h5A3C_1EF0, 8'hA5);
      wait_idle();
   endtask

   task automatic test_rgb32();
      write_reg(CSR_PIXEL_FORMAT, 32'(FMT_RGB32));
      write_reg(CSR_FORCE_OPAQUE, 32'h0);
      send_item(OP_CONVERT, 32'h0012_3456, 8'h00);
      send_item(OP_CONVERT, 32'hFF00_FF00, 8'h00);
      wait_idle();
      write_reg(CSR_FORCE_OPAQUE, 32'h1);
      send_item(OP_CONVERT, 32'h1234_5678, 8'h00);
      send_item(OP_CONVERT, 32'h00FF_00FF, 8'h00);
      wait_idle();
   endtask

   task automatic test_palette();
      write_reg(CSR_PIXEL_FORMAT, 32'(FMT_PALETTE));
      // top byte of a palette entry is dropped
      send_item(OP_PAL_WRITE, 32'hFF11_2233, 8'h00);
      send_item(OP_PAL_WRITE, 32'h00AB_CDEF, 8'hFF);
      send_item(OP_PAL_WRITE, 32'h80FF_00FF, 8'h80);
      send_item(OP_CONVERT, 32'hFFFF_FF00, 8'hFF);
      send_item(OP_CONVERT, 32'h0000_00FF, 8'h00);
      send_item(OP_CONVERT, 32'h1234_5680, 8'h3C);
      // entry never written reads as zero
      send_item(OP_CONVERT, 32'h0000_0007, 8'h07);
      send_item(OP_PAL_WRITE, 32'h0055_AA55, 8'h00);
      send_item(OP_CONVERT, 32'hAAAA_AA00, 8'h00);
      wait_idle();
   endtask

   task automatic test_bitfields();
      write_reg(CSR_PIXEL_FORMAT, 32'(FMT_BITFIELDS));
      // 5-6-5 with no alpha mask
      write_masks(32'h0000_F800, 32'h0000_07E0, 32'h0000_001F, 32'h0);
      send_item(OP_CONVERT, 32'h0000_FFFF, 8'h00);
      send_item(OP_CONVERT, 32'hFFFF_0000, 8'h00);
      send_item(OP_CONVERT, 32'h0000_8410, 8'h00);
      wait_idle();
      // full-width mask, top bit alone, zero colour mask, mask with a gap
      write_masks(32'hFFFF_FFFF, 32'h8000_0000, 32'h0, 32'h0000_F00F);
      send_item(OP_CONVERT, 32'hFFFF_FFFF, 8'h00);
      send_item(OP_CONVERT, 32'h8000_F001, 8'h00);
      send_item(OP_CONVERT, 32'h1234_5678, 8'h00);
      wait_idle();
   endtask

   task automatic test_random();
      logic        op;
      logic [31:0] word;
      logic [7:0]  idx;
      for (int mode = 0; mode < 4; mode++) begin
         for (int fmt = 0; fmt < 4; fmt++) begin
            write_reg(CSR_PIXEL_FORMAT, 32'(fmt));
            write_reg(CSR_FORCE_OPAQUE, 32'($urandom_range(0, 1)));
            write_masks(rand_mask(), rand_mask(), rand_mask(), rand_mask());
            set_idling(mode);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
               // palette phases write more often, and half the items stay in a small window of entries
               op = ($urandom_range(0, 99) < ((cur_format == FMT_PALETTE) ? 30 : 5))
                    ? OP_PAL_WRITE : OP_CONVERT;
               case ($urandom_range(0, 9))
                  0: word = 32'h0;
                  1: word = 32'hFFFF_FFFF;
                  default: word = $urandom();
               endcase
               idx = $urandom_range(0, 255);
               if ($urandom_range(0, 1) == 1) begin
                  word[7:0] = $urandom_range(0, 15);
                  idx       = $urandom_range(0, 15);
               end
               send_item(op, word, idx);
            end
            set_idling(0);
            wait_idle();
         end
      end
   endtask

   initial begin
      csr_we               = 1'b0;
      csr_index            = '0;
      csr_wdata            = '0;
      req_if.valid         = 1'b0;
      req_if.operation     = OP_CONVERT;
      req_if.pixel_word    = '0;
      req_if.palette_index = '0;
      rsp_if.ready         = 1'b1;
      cur_format           = FMT_RGB24;
      cur_opaque           = 1'b0;
      for (int c = 0; c < NUM_CH; c++) begin
         cur_mask[c] = MASK_RESET[c];
      end
      for (int i = 0; i < PALETTE_DEPTH; i++) begin
         palette_rgb[i] = '0;
      end
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_rgb24();
      test_rgb32();
      test_palette();
      test_bitfields();
      test_random();
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT_CYCLES * 2 * HALF_PERIOD);
      $display("Verification failed");
      $finish;
   end

endmodule
